### design/cc20_pkg.sv
package cc20_pkg;

  localparam int unsigned DoubleRoundsDefault = 10;
  localparam int unsigned NumRegs = 7;
  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2,
    KIND_LONG  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_NONCE0 = 3'd4,
    REG_NONCE1 = 3'd5,
    REG_CTR    = 3'd6
  } reg_idx_t;

  // Classified item passed from front to back
  typedef struct packed {
    func_t       func;
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_XOR
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

endpackage

### design/cc20_front.sv
// Accepts items, saturates byte count, drops the unused function code and
// holds a small queue toward the back end.
module cc20_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     func,
  input  logic [63:0]    data_bytes,
  input  logic [3:0]     byte_count,
  input  logic           last_chunk,
  output logic           cmd_valid,
  output cc20_pkg::cmd_t cmd,
  input  logic           cmd_take
);
  import cc20_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            queue [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;
  cmd_t            incoming;
  logic            do_push;
  logic            do_pop;

  // Classify the incoming item
  always_comb begin
    incoming.func  = func_t'(func);
    incoming.data  = data_bytes;
    incoming.count = (byte_count > 4'd8) ? 4'd8 : byte_count;
    incoming.last  = last_chunk;
  end

  assign full      = (fill == (PtrW+1)'(QueueDepth));
  assign do_pop    = cmd_valid && cmd_take;
  assign do_push   = push && !full && (func_t'(func) != FUNC_NONE);
  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

endmodule

### design/cc20_back.sv
// Executes items: session setup, iterative block function (one column or
// diagonal round a cycle), keystream XOR, and a one-entry output register.
module cc20_back #(
  parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DoubleRoundsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [63:0]    key0,
  input  logic [63:0]    key1,
  input  logic [63:0]    key2,
  input  logic [63:0]    key3,
  input  logic [63:0]    nonce0,
  input  logic [31:0]    nonce1,
  input  logic [31:0]    ctr0,
  input  logic           cmd_valid,
  input  cc20_pkg::cmd_t cmd,
  output logic           cmd_take,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     result_kind,
  output logic [63:0]    out_bytes,
  output logic [3:0]     out_count,
  output logic           packet_end
);
  import cc20_pkg::*;

  localparam int unsigned RndW = $clog2(2 * DOUBLE_ROUNDS);
  localparam int unsigned LastRnd = 2 * DOUBLE_ROUNDS - 1;

  state_t        state;
  state_t        state_next;
  logic [31:0]   bin [16];
  logic [31:0]   work [16];
  logic [31:0]   work_next [16];
  logic [31:0]   ks [16];
  logic [RndW-1:0] rnd;
  logic [6:0]    offset;
  logic          ks_ready;
  logic          out_full;
  logic          out_free;
  logic          start_blk;
  logic          finish;
  logic [511:0]  ks_flat;
  logic [63:0]   ks_win;
  logic [63:0]   xored;
  logic [7:0]    fit;
  logic          too_long;

  assign out_free = !out_full || pop;
  assign empty    = !out_full;

  // Half of a double round: columns on even steps, diagonals on odd steps
  always_comb begin
    logic [31:0] w [16];
    int unsigned qa [8];
    int unsigned qb [8];
    int unsigned qc [8];
    int unsigned qd [8];
    int q;
    qa = '{0, 1, 2, 3, 0, 1, 2, 3};
    qb = '{4, 5, 6, 7, 5, 6, 7, 4};
    qc = '{8, 9, 10, 11, 10, 11, 8, 9};
    qd = '{12, 13, 14, 15, 15, 12, 13, 14};
    w = work;
    for (int j = 0; j < 4; j++) begin
      q = rnd[0] ? j + 4 : j;
      w[qa[q]] = w[qa[q]] + w[qb[q]]; w[qd[q]] = rotl(w[qd[q]] ^ w[qa[q]], 16);
      w[qc[q]] = w[qc[q]] + w[qd[q]]; w[qb[q]] = rotl(w[qb[q]] ^ w[qc[q]], 12);
      w[qa[q]] = w[qa[q]] + w[qb[q]]; w[qd[q]] = rotl(w[qd[q]] ^ w[qa[q]], 8);
      w[qc[q]] = w[qc[q]] + w[qd[q]]; w[qb[q]] = rotl(w[qb[q]] ^ w[qc[q]], 7);
    end
    work_next = w;
  end

  // Keystream window at the packet offset
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ks_flat[32*i +: 32] = ks[i];
    end
    ks_win = 64'(ks_flat >> {offset[5:0], 3'b000});
    if (offset[5:0] > 6'd56) begin
      ks_win = ks_win | 64'(ks_flat << {7'd64 - 7'(offset[5:0]), 3'b000});
    end
    for (int i = 0; i < 8; i++) begin
      fit[i] = (4'(i) < cmd.count);
    end
    for (int i = 0; i < 8; i++) begin
      xored[8*i +: 8] = fit[i] ? (cmd.data[8*i +: 8] ^ ks_win[8*i +: 8]) : 8'h00;
    end
    too_long = (8'(offset) + 8'(cmd.count)) > 8'd64;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.func == FUNC_DATA) begin
          state_next = ks_ready ? ST_XOR : ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == RndW'(LastRnd)) begin
          state_next = ST_XOR;
        end
      end
      ST_XOR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    cmd_take  = 1'b0;
    start_blk = 1'b0;
    finish    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.func != FUNC_DATA && out_free) begin
          cmd_take = 1'b1;
        end
        start_blk = cmd_valid && cmd.func == FUNC_DATA && !ks_ready;
      end
      ST_ROUND: ;
      ST_XOR: begin
        finish   = out_free;
        cmd_take = out_free;
      end
      default: ;
    endcase
  end

  // Block function datapath
  always_ff @(posedge clk) begin
    if (start_blk) begin
      work <= bin;
    end else if (state == ST_ROUND) begin
      work <= work_next;
      if (rnd == RndW'(LastRnd)) begin
        for (int i = 0; i < 16; i++) begin
          ks[i] <= work_next[i] + bin[i];
        end
      end
    end
  end

  // Control, block input and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rnd      <= '0;
      offset   <= '0;
      ks_ready <= 1'b0;
      out_full <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        bin[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (pop && out_full) begin
        out_full <= 1'b0;
      end
      if (start_blk) begin
        rnd <= '0;
      end else if (state == ST_ROUND) begin
        rnd <= rnd + 1'b1;
        if (rnd == RndW'(LastRnd)) begin
          ks_ready <= 1'b1;
        end
      end
      if (state == ST_IDLE && cmd_take) begin
        out_full    <= 1'b1;
        result_kind <= (cmd.func == FUNC_START) ? KIND_START : KIND_END;
        out_bytes   <= '0;
        out_count   <= '0;
        packet_end  <= 1'b0;
        offset      <= '0;
        ks_ready    <= 1'b0;
        if (cmd.func == FUNC_START) begin
          bin[0]  <= Sigma0;
          bin[1]  <= Sigma1;
          bin[2]  <= Sigma2;
          bin[3]  <= Sigma3;
          bin[4]  <= key0[31:0];
          bin[5]  <= key0[63:32];
          bin[6]  <= key1[31:0];
          bin[7]  <= key1[63:32];
          bin[8]  <= key2[31:0];
          bin[9]  <= key2[63:32];
          bin[10] <= key3[31:0];
          bin[11] <= key3[63:32];
          bin[12] <= ctr0;
          bin[13] <= nonce0[31:0];
          bin[14] <= nonce0[63:32];
          bin[15] <= nonce1;
        end else begin
          for (int i = 0; i < 16; i++) begin
            bin[i] <= '0;
          end
        end
      end
      if (finish) begin
        out_full   <= 1'b1;
        packet_end <= cmd.last;
        if (too_long) begin
          result_kind <= KIND_LONG;
          out_bytes   <= '0;
          out_count   <= '0;
        end else begin
          result_kind <= KIND_DATA;
          out_bytes   <= xored;
          out_count   <= cmd.count;
          offset      <= offset + 7'(cmd.count);
        end
        if (cmd.last) begin
          bin[12]  <= bin[12] + 32'd1;
          offset   <= '0;
          ks_ready <= 1'b0;
        end
      end
    end
  end

endmodule

### design/chacha20_packet_cipher.sv
// ChaCha20 packet cipher, 96-bit nonce, 32-bit block counter.
// Input queue side: push/full with func, data_bytes, byte_count, last_chunk.
// Result queue side: empty/pop; the oldest result sits on result_kind,
// out_bytes, out_count and packet_end while empty is low.
// Configuration: cfg_valid/cfg_ready with cfg_index (0..6) and cfg_data;
// registers are read only when a start item executes.
// A start or end item completes directly from the idle state once the output register is free.
// The first data chunk of a packet runs the block function, one column or
// diagonal round per cycle, before its XOR; later chunks of the packet
// reuse that keystream block and go straight to the XOR. A full 64-byte
// packet of eight chunks is served from one keystream block.
// A two-entry queue separates the front from the executing back end.
// Reset clears the block state to zero, so data before a start passes
// through unchanged. When the receiver stalls, the one-entry output
// register holds, the back end waits, and full rises once the queue fills.
module chacha20_packet_cipher #(
  parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DoubleRoundsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [63:0] data_bytes,
  input  logic [3:0]  byte_count,
  input  logic        last_chunk,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_count,
  output logic        packet_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import cc20_pkg::*;

  logic [63:0] regs64 [5];
  logic [31:0] nonce1;
  logic [31:0] ctr0;
  logic        cmd_valid;
  logic        cmd_take;
  cmd_t        cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        regs64[i] <= '0;
      end
      nonce1 <= '0;
      ctr0   <= '0;
    end else if (cfg_valid) begin
      priority case (reg_idx_t'(cfg_index))
        REG_NONCE1: nonce1 <= cfg_data[31:0];
        REG_CTR:    ctr0   <= cfg_data[31:0];
        default: begin
          if (cfg_index < 3'(NumRegs - 2)) begin
            regs64[cfg_index] <= cfg_data;
          end
        end
      endcase
    end
  end

  cc20_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .data_bytes (data_bytes),
    .byte_count (byte_count),
    .last_chunk (last_chunk),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  cc20_back #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .key0        (regs64[0]),
    .key1        (regs64[1]),
    .key2        (regs64[2]),
    .key3        (regs64[3]),
    .nonce0      (regs64[4]),
    .nonce1      (nonce1),
    .ctr0        (ctr0),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .result_kind (result_kind),
    .out_bytes   (out_bytes),
    .out_count   (out_count),
    .packet_end  (packet_end)
  );

endmodule
